FILE: rtl/core/dsq_pkg.sv
// Shared constants for the delta sleep queue: field widths, action codes and release limit.
`timescale 1ns / 1ps

package dsq_pkg;

  localparam int ID_WIDTH     = 4;
  localparam int TICKS_WIDTH  = 32;
  localparam int ACTION_WIDTH = 2;

  localparam logic [ACTION_WIDTH-1:0] ACT_SLEEP   = 2'd0;
  localparam logic [ACTION_WIDTH-1:0] ACT_TICK    = 2'd1;
  localparam logic [ACTION_WIDTH-1:0] ACT_RELEASE = 2'd2;

  // Most threads woken by a single release word.
  localparam int RESULT_LIMIT = 16;
  localparam int NW           = $clog2(RESULT_LIMIT + 1);

endpackage

FILE: rtl/core/dsq_req_if.sv
// Request channel of the delta sleep queue: valid, ready and the request word.
`timescale 1ns / 1ps

interface dsq_req_if import dsq_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic [ACTION_WIDTH-1:0] action;
  logic [ID_WIDTH-1:0]     thread_id;
  logic [TICKS_WIDTH-1:0]  sleep_ticks;

  modport source (output valid, output action, output thread_id, output sleep_ticks,
                  input ready);
  modport sink (input valid, input action, input thread_id, input sleep_ticks,
                output ready);

endinterface

FILE: rtl/core/dsq_rsp_if.sv
// Response channel of the delta sleep queue: valid, ready and the result word.
`timescale 1ns / 1ps

interface dsq_rsp_if import dsq_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [ID_WIDTH-1:0] woken_id;
  logic                woken_valid;
  logic                full_error;
  logic                last;

  modport source (output valid, output woken_id, output woken_valid, output full_error,
                  output last, input ready);
  modport sink (input valid, input woken_id, input woken_valid, input full_error,
                input last, output ready);

endinterface

FILE: rtl/core/dsq_row_mem.sv
// Entry memory of the sleep queue: one write port and one registered read port.
`timescale 1ns / 1ps

module dsq_row_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 36
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/delta_sleep_queue_core.sv
// Top level of the delta sleep queue: delta list held in a ring of memory rows.
//
//   Channel  Role    Word
//   req      sink    action, thread_id, sleep_ticks
//   rsp      source  woken_id, woken_valid, full_error, last
//
// A sleep word walks the list, moves the later entries up one row, rewrites its
// successor's delta and writes the new entry; a refused sleep word only answers
// with full_error. A tick decrements a nonzero head delta; a release wakes the head
// entries with zero delta; a tick or a release on an empty list does nothing.
// Reset clears the count and ring head; the entry memory is never cleared.
// A stalled response holds the engine only when a further result must be loaded.
`timescale 1ns / 1ps

module delta_sleep_queue_core import dsq_pkg::*; #(
  parameter int MAX_SLEEPERS = 16,
  parameter int DELTA_WIDTH  = 32
) (
  input logic       clk,
  input logic       rst,
  dsq_req_if.sink   req,
  dsq_rsp_if.source rsp
);

  localparam int AW = $clog2(MAX_SLEEPERS);
  localparam int CW = $clog2(MAX_SLEEPERS + 1);
  localparam int SW = CW + 1;
  localparam int RW = ID_WIDTH + DELTA_WIDTH;

  typedef struct packed {
    logic [ID_WIDTH-1:0]    thread;
    logic [DELTA_WIDTH-1:0] delta;
  } row_t;

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_FIX, S_SHIFT, S_SUCC, S_PLACE, S_EMIT, S_TICK, S_REL
  } state_t;

  state_t                 state;
  logic [AW-1:0]          head;
  logic [CW-1:0]          count;
  logic [CW-1:0]          p;
  logic [CW-1:0]          pos;
  logic [CW-1:0]          j;
  logic [DELTA_WIDTH-1:0] cum;
  logic [DELTA_WIDTH-1:0] diff;
  logic [DELTA_WIDTH-1:0] tsat;
  logic [ID_WIDTH-1:0]    id;
  logic                   err;
  logic                   has_succ;
  row_t                   succ;
  logic [NW-1:0]          n;
  logic                   have_pend;
  logic [ID_WIDTH-1:0]    pend_id;

  logic                   out_valid;
  logic [ID_WIDTH-1:0]    out_id;
  logic                   out_woken;
  logic                   out_err;
  logic                   out_last;
  logic                   out_load;

  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  row_t                   wr_row;
  logic [AW-1:0]          rd_addr;
  logic [RW-1:0]          rd_data;
  row_t                   rd_row;

  logic                   slot_free;
  logic [DELTA_WIDTH-1:0] cand;
  logic                   due;
  logic [AW-1:0]          head_inc;
  logic [DELTA_WIDTH-1:0] adj;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] l);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(l);
    if (s >= SW'(MAX_SLEEPERS)) begin
      s = s - SW'(MAX_SLEEPERS);
    end
    return AW'(s);
  endfunction

  function automatic logic [DELTA_WIDTH-1:0] sat_ticks(input logic [TICKS_WIDTH-1:0] t);
    logic [63:0] w;
    w = 64'(t);
    if ((w >> DELTA_WIDTH) != 64'd0) begin
      return '1;
    end
    return DELTA_WIDTH'(w);
  endfunction

  dsq_row_mem #(
    .DEPTH (MAX_SLEEPERS),
    .WIDTH (RW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (RW'(wr_row)),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_row    = row_t'(rd_data);
  assign slot_free = !out_valid || rsp.ready;
  assign out_load  = slot_free && ((state == S_EMIT) || ((state == S_REL) && have_pend));
  assign cand      = cum + rd_row.delta;
  assign due       = (count != '0) && (rd_row.delta == '0) && (n < NW'(RESULT_LIMIT));
  assign head_inc  = (head == AW'(MAX_SLEEPERS - 1)) ? '0 : head + 1'b1;
  assign adj       = (succ.delta >= diff) ? succ.delta - diff : '0;

  always_comb begin
    rd_addr = head;
    wr_en   = 1'b0;
    wr_addr = phys(head, pos);
    wr_row  = '0;
    case (state)
      S_WALK: begin
        if (cand <= tsat && CW'(p + 1'b1) < count) begin
          rd_addr = phys(head, CW'(p + 1'b1));
        end
      end
      S_FIX: begin
        rd_addr = phys(head, CW'(count - 1'b1));
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = phys(head, CW'(j + 1'b1));
        wr_row  = rd_row;
        rd_addr = phys(head, CW'(j - 1'b1));
      end
      S_SUCC: begin
        wr_en   = 1'b1;
        wr_addr = phys(head, CW'(pos + 1'b1));
        wr_row  = '{thread: succ.thread, delta: adj};
      end
      S_PLACE: begin
        wr_en  = 1'b1;
        wr_row = '{thread: id, delta: diff};
      end
      S_TICK: begin
        wr_en   = (rd_row.delta != '0);
        wr_addr = head;
        wr_row  = '{thread: rd_row.thread, delta: rd_row.delta - 1'b1};
      end
      S_REL: begin
        if (due && (!have_pend || slot_free)) begin
          rd_addr = head_inc;
        end
      end
      default: begin
        rd_addr = head;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      p         <= '0;
      pos       <= '0;
      j         <= '0;
      n         <= '0;
      has_succ  <= 1'b0;
      have_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            id   <= req.thread_id;
            tsat <= sat_ticks(req.sleep_ticks);
            case (req.action)
              ACT_SLEEP: begin
                if (count == CW'(MAX_SLEEPERS)) begin
                  err   <= 1'b1;
                  state <= S_EMIT;
                end else begin
                  err <= 1'b0;
                  cum <= '0;
                  p   <= '0;
                  if (count == '0) begin
                    pos      <= '0;
                    has_succ <= 1'b0;
                    state    <= S_FIX;
                  end else begin
                    state <= S_WALK;
                  end
                end
              end
              ACT_TICK: begin
                if (count != '0) begin
                  state <= S_TICK;
                end
              end
              ACT_RELEASE: begin
                if (count != '0) begin
                  n         <= '0;
                  have_pend <= 1'b0;
                  state     <= S_REL;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_WALK: begin
          if (cand <= tsat) begin
            cum <= cand;
            if (CW'(p + 1'b1) < count) begin
              p <= p + 1'b1;
            end else begin
              pos      <= count;
              has_succ <= 1'b0;
              state    <= S_FIX;
            end
          end else begin
            pos      <= p;
            succ     <= rd_row;
            has_succ <= 1'b1;
            state    <= S_FIX;
          end
        end
        S_FIX: begin
          diff <= tsat - cum;
          if (has_succ) begin
            j <= count - 1'b1;
            if (CW'(count - 1'b1) > pos) begin
              state <= S_SHIFT;
            end else begin
              state <= S_SUCC;
            end
          end else begin
            state <= S_PLACE;
          end
        end
        S_SHIFT: begin
          if (j > CW'(pos + 1'b1)) begin
            j <= j - 1'b1;
          end else begin
            state <= S_SUCC;
          end
        end
        S_SUCC: begin
          state <= S_PLACE;
        end
        S_PLACE: begin
          count <= count + 1'b1;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_id    <= '0;
            out_woken <= 1'b0;
            out_err   <= err;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_TICK: begin
          state <= S_IDLE;
        end
        S_REL: begin
          if (due) begin
            if (!have_pend || slot_free) begin
              if (have_pend) begin
                out_id    <= pend_id;
                out_woken <= 1'b1;
                out_err   <= 1'b0;
                out_last  <= 1'b0;
              end
              pend_id   <= rd_row.thread;
              have_pend <= 1'b1;
              head      <= head_inc;
              count     <= count - 1'b1;
              n         <= n + 1'b1;
            end
          end else if (!have_pend) begin
            state <= S_IDLE;
          end else if (slot_free) begin
            out_id    <= pend_id;
            out_woken <= 1'b1;
            out_err   <= 1'b0;
            out_last  <= 1'b1;
            have_pend <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.woken_id    = out_id;
  assign rsp.woken_valid = out_woken;
  assign rsp.full_error  = out_err;
  assign rsp.last        = out_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SLEEPERS))
    else $error("sleeper count exceeds the list depth");

  a_release_limit: assert property (@(posedge clk) disable iff (rst)
    n <= NW'(RESULT_LIMIT))
    else $error("release woke more threads than one word allows");

  a_release_no_grow: assert property (@(posedge clk) disable iff (rst)
    state == S_REL |=> count <= $past(count))
    else $error("release raised the sleeper count");

  a_place_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_PLACE |-> (pos <= count) && (count < CW'(MAX_SLEEPERS)))
    else $error("insert position lies outside the live list");

endmodule
